// ----- rtl/core/abrf_pkg.sv -----
// ----------------------------------------------------------------------------
// abrf_pkg
// Shared types, mode codes and helper functions for the banked register file.
// ----------------------------------------------------------------------------
package abrf_pkg;

  // Action codes carried on the action port.
  typedef enum logic [2:0] {
    ACT_READ_REG   = 3'd0,
    ACT_WRITE_REG  = 3'd1,
    ACT_WRITE_CPSR = 3'd2,
    ACT_READ_SPSR  = 3'd3,
    ACT_WRITE_SPSR = 3'd4,
    ACT_EXCEPTION  = 3'd5,
    ACT_COND_TEST  = 3'd6,
    ACT_NONE       = 3'd7
  } action_t;

  // Internal mode index; MODE_BAD flags an undefined mode field.
  typedef enum logic [2:0] {
    MODE_USR = 3'd0,
    MODE_FIQ = 3'd1,
    MODE_IRQ = 3'd2,
    MODE_SVC = 3'd3,
    MODE_ABT = 3'd4,
    MODE_UND = 3'd5,
    MODE_SYS = 3'd6,
    MODE_BAD = 3'd7
  } mode_t;

  // Architectural mode field encodings.
  localparam logic [4:0] MBITS_USR = 5'h10;
  localparam logic [4:0] MBITS_FIQ = 5'h11;
  localparam logic [4:0] MBITS_IRQ = 5'h12;
  localparam logic [4:0] MBITS_SVC = 5'h13;
  localparam logic [4:0] MBITS_ABT = 5'h17;
  localparam logic [4:0] MBITS_UND = 5'h1B;
  localparam logic [4:0] MBITS_SYS = 5'h1F;

  localparam logic [31:0] RESET_SP  = 32'h0300_7F00;
  localparam logic [31:0] RESET_PSR = 32'h6000_001F;
  localparam logic [31:0] RESET_R0  = 32'h0800_0000;
  localparam logic [31:0] RESET_R1  = 32'h0000_00EA;

  localparam int T_BIT = 5;
  localparam int I_BIT = 7;

  // FSM states of the controller.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RESP = 2'd2
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture the input beat
    logic exec;   // perform the action and register the result
  } cmd_t;

  function automatic mode_t decode_mode(input logic [4:0] bits);
    mode_t m;
    case (bits)
      MBITS_USR: m = MODE_USR;
      MBITS_FIQ: m = MODE_FIQ;
      MBITS_IRQ: m = MODE_IRQ;
      MBITS_SVC: m = MODE_SVC;
      MBITS_ABT: m = MODE_ABT;
      MBITS_UND: m = MODE_UND;
      MBITS_SYS: m = MODE_SYS;
      default:   m = MODE_BAD;
    endcase
    return m;
  endfunction

  // Privileged exception modes own an SPSR and a private r13/r14 bank.
  function automatic logic has_saved(input mode_t m);
    return (m == MODE_FIQ) || (m == MODE_IRQ) || (m == MODE_SVC) ||
           (m == MODE_ABT) || (m == MODE_UND);
  endfunction

  // r13/r14 bank number; User and System share bank zero.
  function automatic logic [2:0] sl_bank(input mode_t m);
    return has_saved(m) ? 3'(m) : 3'd0;
  endfunction

  function automatic logic cond_holds(input logic [3:0] cond, input logic [31:0] psr);
    logic n, z, c, v, r;
    n = psr[31];
    z = psr[30];
    c = psr[29];
    v = psr[28];
    case (cond)
      4'd0:    r = z;
      4'd1:    r = !z;
      4'd2:    r = c;
      4'd3:    r = !c;
      4'd4:    r = n;
      4'd5:    r = !n;
      4'd6:    r = v;
      4'd7:    r = !v;
      4'd8:    r = c && !z;
      4'd9:    r = !c || z;
      4'd10:   r = (n == v);
      4'd11:   r = (n != v);
      4'd12:   r = !z && (n == v);
      4'd13:   r = z || (n != v);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/arm_banked_register_file_top.sv -----
// ----------------------------------------------------------------------------
// arm_banked_register_file_top
// Mode-banked r0-r14, CPSR/SPSR, exception entry and condition test.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  request  | start / busy        | action, reg_index, write_data,
//           |                     | target_mode_bits, is_irq, pc_value, cond_code
//  result   | done (1-cycle beat) | read_data, psr_now, cond_pass, status
//
//  A beat is taken at an edge with start high and busy low. Each beat goes
//  through capture, an execute step through the bank muxes and the register
//  write port, then the result is shown for exactly one cycle with
//  done high. busy stays high from capture through the result cycle.
//  Synchronous active-high rst restores the reset register contents and the
//  System-mode CPSR; no clearing pass. The receiver cannot stall: done is
//  never held.
// ----------------------------------------------------------------------------
module arm_banked_register_file_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [3:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [4:0]  target_mode_bits,
  input  logic        is_irq,
  input  logic [31:0] pc_value,
  input  logic [3:0]  cond_code,
  output logic        done,
  output logic [31:0] read_data,
  output logic [31:0] psr_now,
  output logic        cond_pass,
  output logic        status
);

  abrf_pkg::cmd_t cmd;

  // Sequencer: IDLE -> EXEC -> RESP
  abrf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Storage and the per-action logic
  abrf_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .action           (action),
    .reg_index        (reg_index),
    .write_data       (write_data),
    .target_mode_bits (target_mode_bits),
    .is_irq           (is_irq),
    .pc_value         (pc_value),
    .cond_code        (cond_code),
    .read_data        (read_data),
    .psr_now          (psr_now),
    .cond_pass        (cond_pass),
    .status           (status)
  );

  // An accepted beat yields its result after passing the EXEC state, with done in RESP.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result strobe missing two cycles after accept");

  // The block is free again right after a result.
  a_free_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy still high after result");

  // A rejected mode leaves CPSR as it was.
  a_bad_mode_keeps_psr: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (psr_now == $past(psr_now)))
    else $error("CPSR changed on invalid mode");

  // CPSR always holds a defined mode field.
  a_mode_defined: assert property (@(posedge clk) disable iff (rst)
    (psr_now[4:0] == abrf_pkg::MBITS_USR) || (psr_now[4:0] == abrf_pkg::MBITS_FIQ) ||
    (psr_now[4:0] == abrf_pkg::MBITS_IRQ) || (psr_now[4:0] == abrf_pkg::MBITS_SVC) ||
    (psr_now[4:0] == abrf_pkg::MBITS_ABT) || (psr_now[4:0] == abrf_pkg::MBITS_UND) ||
    (psr_now[4:0] == abrf_pkg::MBITS_SYS))
    else $error("CPSR holds an undefined mode");

endmodule

// ----- rtl/core/abrf_ctrl.sv -----
// ----------------------------------------------------------------------------
// abrf_ctrl
// Sequencer: captures a beat, runs the execute state, presents the result.
// ----------------------------------------------------------------------------
module abrf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output abrf_pkg::cmd_t  cmd
);

  abrf_pkg::state_t state;
  abrf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abrf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      abrf_pkg::ST_IDLE: state_next = start ? abrf_pkg::ST_EXEC : abrf_pkg::ST_IDLE;
      abrf_pkg::ST_EXEC: state_next = abrf_pkg::ST_RESP;
      abrf_pkg::ST_RESP: state_next = abrf_pkg::ST_IDLE;
      default:           state_next = abrf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    done     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    case (state)
      abrf_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      abrf_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      abrf_pkg::ST_RESP: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/core/abrf_datapath.sv -----
// ----------------------------------------------------------------------------
// abrf_datapath
// Banked register storage, CPSR/SPSR, link formation and condition check.
// ----------------------------------------------------------------------------
module abrf_datapath (
  input  logic            clk,
  input  logic            rst,
  input  abrf_pkg::cmd_t  cmd,
  input  logic [2:0]      action,
  input  logic [3:0]      reg_index,
  input  logic [31:0]     write_data,
  input  logic [4:0]      target_mode_bits,
  input  logic            is_irq,
  input  logic [31:0]     pc_value,
  input  logic [3:0]      cond_code,
  output logic [31:0]     read_data,
  output logic [31:0]     psr_now,
  output logic            cond_pass,
  output logic            status
);

  // Captured beat
  abrf_pkg::action_t act_q;
  logic [3:0]        idx_q;
  logic [31:0]       data_q;
  logic [4:0]        tbits_q;
  logic              irq_q;
  logic [31:0]       pc_q;
  logic [3:0]        cond_q;

  // Architectural state
  logic [31:0]     low_regs [8];
  logic [31:0]     hi_shr   [5];
  logic [31:0]     hi_fiq   [5];
  logic [31:0]     sl_regs  [12];
  logic [31:0]     spsr     [5];
  logic [31:0]     cpsr;
  abrf_pkg::mode_t mode;

  // Decode of the captured beat
  logic [2:0]      hi_sel;
  logic [3:0]      sl_sel;
  logic [2:0]      spsr_sel;
  logic [31:0]     reg_rd;
  abrf_pkg::mode_t wr_mode;
  abrf_pkg::mode_t ex_mode;
  logic [3:0]      ex_sl_sel;
  logic [2:0]      ex_spsr_sel;
  logic            thumb;
  logic [31:0]     link;
  logic [31:0]     rd_next;
  logic            pass_next;
  logic            status_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q   <= abrf_pkg::action_t'(action);
      idx_q   <= reg_index;
      data_q  <= write_data;
      tbits_q <= target_mode_bits;
      irq_q   <= is_irq;
      pc_q    <= pc_value;
      cond_q  <= cond_code;
    end
  end

  always_comb begin
    hi_sel      = idx_q[2:0];
    sl_sel      = {abrf_pkg::sl_bank(mode), idx_q[1]};
    spsr_sel    = 3'(mode) - 3'd1;
    wr_mode     = abrf_pkg::decode_mode(data_q[4:0]);
    ex_mode     = abrf_pkg::decode_mode(tbits_q);
    ex_sl_sel   = {abrf_pkg::sl_bank(ex_mode), 1'b1};
    ex_spsr_sel = 3'(ex_mode) - 3'd1;
    thumb       = cpsr[abrf_pkg::T_BIT];
    if (irq_q) begin
      link = thumb ? pc_q : pc_q - 32'd4;
    end else begin
      link = pc_q - (thumb ? 32'd2 : 32'd4);
    end

    if (idx_q < 4'd8) begin
      reg_rd = low_regs[idx_q[2:0]];
    end else if (idx_q < 4'd13) begin
      reg_rd = (mode == abrf_pkg::MODE_FIQ) ? hi_fiq[hi_sel] : hi_shr[hi_sel];
    end else if (idx_q < 4'd15) begin
      reg_rd = sl_regs[sl_sel];
    end else begin
      reg_rd = '0;
    end

    rd_next     = '0;
    pass_next   = 1'b0;
    status_next = 1'b0;
    case (act_q)
      abrf_pkg::ACT_READ_REG:   rd_next = reg_rd;
      abrf_pkg::ACT_WRITE_CPSR: status_next = (wr_mode == abrf_pkg::MODE_BAD);
      abrf_pkg::ACT_READ_SPSR:  rd_next = abrf_pkg::has_saved(mode) ? spsr[spsr_sel] : cpsr;
      abrf_pkg::ACT_WRITE_SPSR: begin
        status_next = !abrf_pkg::has_saved(mode) && (wr_mode == abrf_pkg::MODE_BAD);
      end
      abrf_pkg::ACT_EXCEPTION:  status_next = (ex_mode == abrf_pkg::MODE_BAD);
      abrf_pkg::ACT_COND_TEST:  pass_next = abrf_pkg::cond_holds(cond_q, cpsr);
      default:                  rd_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        low_regs[i] <= '0;
      end
      low_regs[0] <= abrf_pkg::RESET_R0;
      low_regs[1] <= abrf_pkg::RESET_R1;
      for (int i = 0; i < 5; i++) begin
        hi_shr[i] <= '0;
        hi_fiq[i] <= '0;
        spsr[i]   <= '0;
      end
      for (int i = 0; i < 6; i++) begin
        sl_regs[2*i]     <= abrf_pkg::RESET_SP;
        sl_regs[2*i + 1] <= '0;
      end
      cpsr      <= abrf_pkg::RESET_PSR;
      mode      <= abrf_pkg::MODE_SYS;
      read_data <= '0;
      cond_pass <= 1'b0;
      status    <= 1'b0;
    end else if (cmd.exec) begin
      read_data <= rd_next;
      cond_pass <= pass_next;
      status    <= status_next;
      case (act_q)
        abrf_pkg::ACT_WRITE_REG: begin
          if (idx_q < 4'd8) begin
            low_regs[idx_q[2:0]] <= data_q;
          end else if (idx_q < 4'd13) begin
            if (mode == abrf_pkg::MODE_FIQ) begin
              hi_fiq[hi_sel] <= data_q;
            end else begin
              hi_shr[hi_sel] <= data_q;
            end
          end else if (idx_q < 4'd15) begin
            sl_regs[sl_sel] <= data_q;
          end
        end
        abrf_pkg::ACT_WRITE_CPSR: begin
          if (wr_mode != abrf_pkg::MODE_BAD) begin
            cpsr <= data_q;
            mode <= wr_mode;
          end
        end
        abrf_pkg::ACT_WRITE_SPSR: begin
          if (abrf_pkg::has_saved(mode)) begin
            spsr[spsr_sel] <= data_q;
          end else if (wr_mode != abrf_pkg::MODE_BAD) begin
            cpsr <= data_q;
            mode <= wr_mode;
          end
        end
        abrf_pkg::ACT_EXCEPTION: begin
          if (ex_mode != abrf_pkg::MODE_BAD) begin
            sl_regs[ex_sl_sel] <= link;
            if (abrf_pkg::has_saved(ex_mode)) begin
              spsr[ex_spsr_sel] <= cpsr;
            end
            cpsr <= {cpsr[31:8], 1'b1, cpsr[6], 1'b0, tbits_q};
            mode <= ex_mode;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign psr_now = cpsr;

endmodule

// ----- tb/arm_banked_register_file_top_tb.sv -----
// ----------------------------------------------------------------------------
// arm_banked_register_file_top_tb
// Self-checking bench for the banked register file: a shadow copy of the
// banks and PSRs predicts every result beat, which is compared field by field.
// ----------------------------------------------------------------------------
module arm_banked_register_file_top_tb;

  // Directed part, then random traffic up to roughly 1450 request beats.
  localparam int RANDOM_BEATS = 1424;
  // Cycles with no beat in either direction before the run is declared hung.
  // The longest legal quiet stretch is the longest driver gap plus the turn of a beat.
  localparam int IDLE_LIMIT   = 2000;

  // Result beat as the block should present it.
  typedef struct {
    logic [31:0] read_data;
    logic [31:0] psr_now;
    logic        cond_pass;
    logic        status;
  } rf_view_t;

  // --------------------------------------------------------------------------
  // Shadow register file. note_request replays each accepted request beat on
  // a private copy of the banks and queues the result it must produce;
  // check_response pops the oldest and compares it with the block's result.
  // --------------------------------------------------------------------------
  class rf_shadow;
    logic [31:0]     gpr_lo [8];      // r0-r7, one copy for all modes
    logic [31:0]     gpr_hi_usr [5];  // r8-r12 outside FIQ
    logic [31:0]     gpr_hi_fiq [5];  // r8-r12 in FIQ
    logic [31:0]     sp_lr [12];      // r13/r14 pairs, bank 0 = User/System
    logic [31:0]     spsr_bank [5];   // FIQ, IRQ, SVC, ABT, UND
    logic [31:0]     cpsr;
    abrf_pkg::mode_t cur_mode;
    rf_view_t        expected_views [$];
    int              errors;

    function new();
      int i;
      for (i = 0; i < 8; i++) gpr_lo[i] = '0;
      for (i = 0; i < 5; i++) begin
        gpr_hi_usr[i] = '0;
        gpr_hi_fiq[i] = '0;
        spsr_bank[i]  = '0;
      end
      for (i = 0; i < 6; i++) begin
        sp_lr[2 * i]     = abrf_pkg::RESET_SP;
        sp_lr[2 * i + 1] = '0;
      end
      gpr_lo[0] = abrf_pkg::RESET_R0;
      gpr_lo[1] = abrf_pkg::RESET_R1;
      cpsr      = abrf_pkg::RESET_PSR;
      cur_mode  = abrf_pkg::MODE_SYS;
      errors    = 0;
    endfunction

    function abrf_pkg::mode_t mode_from_bits(logic [4:0] b);
      case (b)
        abrf_pkg::MBITS_USR: return abrf_pkg::MODE_USR;
        abrf_pkg::MBITS_FIQ: return abrf_pkg::MODE_FIQ;
        abrf_pkg::MBITS_IRQ: return abrf_pkg::MODE_IRQ;
        abrf_pkg::MBITS_SVC: return abrf_pkg::MODE_SVC;
        abrf_pkg::MBITS_ABT: return abrf_pkg::MODE_ABT;
        abrf_pkg::MBITS_UND: return abrf_pkg::MODE_UND;
        abrf_pkg::MBITS_SYS: return abrf_pkg::MODE_SYS;
        default:             return abrf_pkg::MODE_BAD;
      endcase
    endfunction

    function bit owns_spsr(abrf_pkg::mode_t m);
      return !(m == abrf_pkg::MODE_USR || m == abrf_pkg::MODE_SYS ||
               m == abrf_pkg::MODE_BAD);
    endfunction

    function int bank_of(abrf_pkg::mode_t m);
      return owns_spsr(m) ? int'(m) : 0;
    endfunction

    // Odd codes invert the even code below them; 14 and 15 always pass.
    function bit cond_ok(logic [3:0] cc);
      logic n, z, c, v, base;
      n = cpsr[31];
      z = cpsr[30];
      c = cpsr[29];
      v = cpsr[28];
      case (cc[3:1])
        3'd0:    base = z;
        3'd1:    base = c;
        3'd2:    base = n;
        3'd3:    base = v;
        3'd4:    base = c & ~z;
        3'd5:    base = ~(n ^ v);
        3'd6:    base = ~z & ~(n ^ v);
        default: return 1'b1;
      endcase
      return base ^ cc[0];
    endfunction

    function logic [31:0] reg_value(logic [3:0] idx);
      int k;
      k = int'(idx);
      if (k < 8) return gpr_lo[k];
      if (k < 13) return (cur_mode == abrf_pkg::MODE_FIQ) ? gpr_hi_fiq[k - 8] :
                                                            gpr_hi_usr[k - 8];
      if (k < 15) return sp_lr[2 * bank_of(cur_mode) + k - 13];
      return '0;  // r15 is not held here
    endfunction

    function void reg_store(logic [3:0] idx, logic [31:0] d);
      int k;
      k = int'(idx);
      if (k < 8) gpr_lo[k] = d;
      else if (k < 13) begin
        if (cur_mode == abrf_pkg::MODE_FIQ) gpr_hi_fiq[k - 8] = d;
        else gpr_hi_usr[k - 8] = d;
      end else if (k < 15) sp_lr[2 * bank_of(cur_mode) + k - 13] = d;
    endfunction

    // Returns the status bit: undefined mode field leaves everything alone.
    function logic load_cpsr(logic [31:0] d);
      abrf_pkg::mode_t m;
      m = mode_from_bits(d[4:0]);
      if (m == abrf_pkg::MODE_BAD) return 1'b1;
      cpsr     = d;
      cur_mode = m;
      return 1'b0;
    endfunction

    function void note_request(abrf_pkg::action_t act, logic [3:0] idx,
                               logic [31:0] data, logic [4:0] tbits, logic irq,
                               logic [31:0] pc, logic [3:0] cc);
      rf_view_t        v;
      abrf_pkg::mode_t m;
      logic [31:0]     link;
      v.read_data = '0;
      v.cond_pass = 1'b0;
      v.status    = 1'b0;
      case (act)
        abrf_pkg::ACT_READ_REG:   v.read_data = reg_value(idx);
        abrf_pkg::ACT_WRITE_REG:  reg_store(idx, data);
        abrf_pkg::ACT_WRITE_CPSR: v.status = load_cpsr(data);
        abrf_pkg::ACT_READ_SPSR:  v.read_data = owns_spsr(cur_mode) ?
                                                spsr_bank[int'(cur_mode) - 1] : cpsr;
        abrf_pkg::ACT_WRITE_SPSR: begin
          if (owns_spsr(cur_mode)) spsr_bank[int'(cur_mode) - 1] = data;
          else v.status = load_cpsr(data);
        end
        abrf_pkg::ACT_EXCEPTION: begin
          m = mode_from_bits(tbits);
          if (m == abrf_pkg::MODE_BAD) begin
            v.status = 1'b1;
          end else begin
            if (irq) link = cpsr[abrf_pkg::T_BIT] ? pc : pc - 32'd4;
            else link = cpsr[abrf_pkg::T_BIT] ? pc - 32'd2 : pc - 32'd4;
            sp_lr[2 * bank_of(m) + 1] = link;
            if (owns_spsr(m)) spsr_bank[int'(m) - 1] = cpsr;
            // new mode field, I set, T cleared, flags and F kept
            cpsr = {cpsr[31:8], 1'b1, cpsr[6], 1'b0, tbits};
            cur_mode = m;
          end
        end
        abrf_pkg::ACT_COND_TEST:  v.cond_pass = cond_ok(cc);
        default: ;
      endcase
      v.psr_now = cpsr;
      expected_views.push_back(v);
    endfunction

    function void check_response(logic [31:0] rd, logic [31:0] psr, logic pass,
                                 logic st);
      rf_view_t e;
      if (expected_views.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected: read_data %h psr_now %h", $time,
                 rd, psr);
        return;
      end
      e = expected_views.pop_front();
      if (e.read_data !== rd) begin
        errors++;
        $display("%0t: read_data expected %h actual %h", $time, e.read_data, rd);
      end
      if (e.psr_now !== psr) begin
        errors++;
        $display("%0t: psr_now expected %h actual %h", $time, e.psr_now, psr);
      end
      if (e.cond_pass !== pass) begin
        errors++;
        $display("%0t: cond_pass expected %b actual %b", $time, e.cond_pass, pass);
      end
      if (e.status !== st) begin
        errors++;
        $display("%0t: status expected %b actual %b", $time, e.status, st);
      end
    endfunction

    function int outstanding();
      return expected_views.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block hookup. All inputs start at known values.
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  abrf_pkg::action_t action = abrf_pkg::ACT_READ_REG;
  logic [3:0]        reg_index = '0;
  logic [31:0]       write_data = '0;
  logic [4:0]        target_mode_bits = '0;
  logic              is_irq = 1'b0;
  logic [31:0]       pc_value = '0;
  logic [3:0]        cond_code = '0;
  logic              busy;
  logic              done;
  logic [31:0]       read_data;
  logic [31:0]       psr_now;
  logic              cond_pass;
  logic              status;

  rf_shadow    sb;
  bit          no_idle_run = 1'b0;  // burst stretch: back-to-back requests
  int unsigned idle_cycles = 0;

  always #10 clk = ~clk;

  arm_banked_register_file_top dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .action           (action),
    .reg_index        (reg_index),
    .write_data       (write_data),
    .target_mode_bits (target_mode_bits),
    .is_irq           (is_irq),
    .pc_value         (pc_value),
    .cond_code        (cond_code),
    .done             (done),
    .read_data        (read_data),
    .psr_now          (psr_now),
    .cond_pass        (cond_pass),
    .status           (status)
  );

  // Monitor: everything is sampled at the rising edge, before the NBAs of that
  // edge land, so the request seen here is exactly the beat the block takes.
  // The result beat is checked first; it always belongs to an older request.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_response(read_data, psr_now, cond_pass, status);
      if (start && !busy)
        sb.note_request(action, reg_index, write_data, target_mode_bits, is_irq,
                        pc_value, cond_code);
    end
  end

  // Watchdog: restarts on any beat in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. A random gap with start low precedes each beat unless a
  // burst stretch is on; start then stays high until the beat is taken. With
  // no gap, start is simply left high and the payload changes under it.
  // --------------------------------------------------------------------------
  task automatic send_beat(input abrf_pkg::action_t act, input logic [3:0] idx,
                           input logic [31:0] data, input logic [4:0] tbits,
                           input logic irq, input logic [31:0] pc,
                           input logic [3:0] cc);
    int gap;
    gap = no_idle_run ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    action           <= act;
    reg_index        <= idx;
    write_data       <= data;
    target_mode_bits <= tbits;
    is_irq           <= irq;
    pc_value         <= pc;
    cond_code        <= cc;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [4:0] any_mode_bits();
    case ($urandom_range(0, 6))
      0:       return abrf_pkg::MBITS_USR;
      1:       return abrf_pkg::MBITS_FIQ;
      2:       return abrf_pkg::MBITS_IRQ;
      3:       return abrf_pkg::MBITS_SVC;
      4:       return abrf_pkg::MBITS_ABT;
      5:       return abrf_pkg::MBITS_UND;
      default: return abrf_pkg::MBITS_SYS;
    endcase
  endfunction

  // Mostly legal mode fields so the traffic roams over all banks; every
  // payload field is random regardless, so unused fields toggle too.
  task automatic send_random_beat();
    abrf_pkg::action_t act;
    logic [3:0]        idx;
    logic [31:0]       data;
    logic [4:0]        tbits;
    logic              irq;
    logic [31:0]       pc;
    logic [3:0]        cc;
    int                pick;
    idx   = 4'($urandom_range(0, 15));
    data  = $urandom;
    tbits = 5'($urandom_range(0, 31));
    irq   = 1'($urandom_range(0, 1));
    pc    = $urandom;
    cc    = 4'($urandom_range(0, 15));
    pick  = $urandom_range(0, 99);
    if (pick < 28) act = abrf_pkg::ACT_READ_REG;
    else if (pick < 46) act = abrf_pkg::ACT_WRITE_REG;
    else if (pick < 58) begin
      act = abrf_pkg::ACT_WRITE_CPSR;
      if ($urandom_range(0, 9) != 0) data[4:0] = any_mode_bits();
    end else if (pick < 66) act = abrf_pkg::ACT_READ_SPSR;
    else if (pick < 74) begin
      act = abrf_pkg::ACT_WRITE_SPSR;
      if ($urandom_range(0, 9) != 0) data[4:0] = any_mode_bits();
    end else if (pick < 86) begin
      act = abrf_pkg::ACT_EXCEPTION;
      if ($urandom_range(0, 9) != 0) tbits = any_mode_bits();
      if ($urandom_range(0, 7) == 0) pc = $urandom_range(0, 3);  // link wraps
    end else if (pick < 98) act = abrf_pkg::ACT_COND_TEST;
    else act = abrf_pkg::ACT_NONE;
    send_beat(act, idx, data, tbits, irq, pc, cc);
  endtask

  initial begin
    int n;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset contents, r15, SPSR in System, condition extremes,
    // undefined mode fields, each link rule in ARM and Thumb state, the FIQ
    // bank, entry into User, SPSR write acting on CPSR, the unused action.
    send_beat(abrf_pkg::ACT_READ_REG,   4'd0,  '0, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_READ_REG,   4'd1,  '0, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_READ_REG,   4'd13, '0, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_WRITE_REG,  4'd15, '1, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_READ_REG,   4'd15, '0, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_READ_SPSR,  4'd0,  '0, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_COND_TEST,  4'd0,  '0, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_COND_TEST,  4'd0,  '0, '0, 1'b0, '0, 4'd15);
    send_beat(abrf_pkg::ACT_WRITE_CPSR, 4'd0,  '0, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_EXCEPTION,  4'd0,  '0, '0, 1'b1, '0, 4'd0);
    send_beat(abrf_pkg::ACT_EXCEPTION,  4'd0,  '0, abrf_pkg::MBITS_IRQ, 1'b1, '0, 4'd0);
    send_beat(abrf_pkg::ACT_READ_REG,   4'd14, '0, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_READ_SPSR,  4'd0,  '0, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_WRITE_SPSR, 4'd0,  '1, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_READ_SPSR,  4'd0,  '0, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_WRITE_CPSR, 4'd0, {24'hF0_0000, 3'b111, abrf_pkg::MBITS_FIQ},
              '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_WRITE_REG,  4'd8,  '1, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_READ_REG,   4'd13, '0, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_EXCEPTION,  4'd0,  '0, abrf_pkg::MBITS_SVC, 1'b0, '1, 4'd0);
    send_beat(abrf_pkg::ACT_WRITE_CPSR, 4'd0, {24'h0, 3'b001, abrf_pkg::MBITS_IRQ},
              '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_EXCEPTION,  4'd0,  '0, abrf_pkg::MBITS_IRQ, 1'b1,
              32'h1234_5678, 4'd0);
    send_beat(abrf_pkg::ACT_EXCEPTION,  4'd0,  '0, abrf_pkg::MBITS_USR, 1'b0,
              32'h0000_0100, 4'd0);
    send_beat(abrf_pkg::ACT_WRITE_SPSR, 4'd0, 32'h0000_0001, '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_WRITE_SPSR, 4'd0, {4'h9, 23'h0, abrf_pkg::MBITS_UND},
              '0, 1'b0, '0, 4'd0);
    send_beat(abrf_pkg::ACT_NONE,       4'd0,  '1, '1, 1'b1, '1, 4'd15);
    send_beat(abrf_pkg::ACT_WRITE_CPSR, 4'd0, {4'h5, 23'h0, abrf_pkg::MBITS_SYS},
              '0, 1'b0, '0, 4'd0);

    // Random traffic; every 50 beats decide whether the next stretch runs
    // back to back.
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) no_idle_run = ($urandom_range(0, 3) == 0);
      send_random_beat();
    end
    start <= 1'b0;

    // Drain: let the monitor log the last beat, then wait for its result and
    // spare cycles after it to catch any stray result beat.
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/abrf_pkg.sv
rtl/core/abrf_ctrl.sv
rtl/core/abrf_datapath.sv
rtl/core/arm_banked_register_file_top.sv
tb/arm_banked_register_file_top_tb.sv
